### hdl/mwt_pkg.sv
`default_nettype none

package mwt_pkg;

    localparam int LOG_MAX_POINTS_DEF = 10;

    // field widths
    localparam int REQ_W      = 2;
    localparam int INDEX_W    = 10;
    localparam int VAL_W      = 30;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int KIND_W     = 2;
    localparam int SIZE_W     = 4;

    localparam logic [VAL_W-1:0] MOD_P = 30'd1000000007;

    // request codes
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RUN   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    // transform kinds
    localparam logic [KIND_W-1:0] KIND_OR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_AND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_XOR = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KIND    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_BF_RD,
        ST_BF_CALC,
        ST_BF_WLO,
        ST_BF_WHI,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic wr_in;     // store the input item's value
        logic rd_in;     // read at the input item's index
        logic clr_cnt;   // start of a run
        logic calc;      // latch sum and differences
        logic wr_lo;
        logic wr_hi;
        logic next_bfly;
        logic out_read;  // load read result
        logic out_done;  // load run completion
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              size_zero;
        logic              last_bfly;
        logic              last_stage;
        logic              out_hold;
    } t_stat;

endpackage

`default_nettype wire

### hdl/mwt_ram.sv
`default_nettype none

module mwt_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic      [WIDTH-1:0]         o_rd_data_a,
    output logic      [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

`default_nettype wire

### hdl/mwt_ctrl.sv
`default_nettype none

module mwt_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic [mwt_pkg::REQ_W-1:0]   i_req_type,
    output logic                             o_ready,
    input  wire mwt_pkg::t_stat              i_stat,
    output mwt_pkg::t_cmd                    o_cmd
);

    import mwt_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;
    logic   last_all;
    logic   kind_ok;

    assign o_ready  = (r_state == ST_IDLE) && !i_stat.out_hold;
    assign accept   = i_valid && o_ready;
    assign last_all = i_stat.last_bfly && i_stat.last_stage;
    assign kind_ok  = (i_stat.kind == KIND_OR) || (i_stat.kind == KIND_AND)
                   || (i_stat.kind == KIND_XOR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_req_type)
                        REQ_READ: n_state = ST_READ;
                        REQ_RUN: begin
                            // unused kind or single point: nothing to do
                            if (kind_ok && !i_stat.size_zero) begin
                                n_state = ST_BF_RD;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ:    n_state = ST_IDLE;
            ST_BF_RD:   n_state = ST_BF_CALC;
            ST_BF_CALC: begin
                if (i_stat.kind == KIND_OR) begin
                    n_state = ST_BF_WHI;
                end else begin
                    n_state = ST_BF_WLO;
                end
            end
            ST_BF_WLO: begin
                if (i_stat.kind == KIND_XOR) begin
                    n_state = ST_BF_WHI;
                end else begin
                    n_state = last_all ? ST_DONE : ST_BF_RD;
                end
            end
            ST_BF_WHI:  n_state = last_all ? ST_DONE : ST_BF_RD;
            ST_DONE:    n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_req_type)
                        REQ_WRITE: o_cmd.wr_in   = 1'b1;
                        REQ_READ:  o_cmd.rd_in   = 1'b1;
                        REQ_RUN:   o_cmd.clr_cnt = 1'b1;
                        default:   o_cmd         = '0;
                    endcase
                end
            end
            ST_READ:    o_cmd.out_read = 1'b1;
            ST_BF_RD:   o_cmd = '0;
            ST_BF_CALC: o_cmd.calc = 1'b1;
            ST_BF_WLO: begin
                o_cmd.wr_lo     = 1'b1;
                o_cmd.next_bfly = (i_stat.kind != KIND_XOR);
            end
            ST_BF_WHI: begin
                o_cmd.wr_hi     = 1'b1;
                o_cmd.next_bfly = 1'b1;
            end
            ST_DONE:    o_cmd.out_done = 1'b1;
            default:    o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

### hdl/mwt_dpath.sv
`default_nettype none

module mwt_dpath #(
    parameter int LOG_MAX_POINTS = mwt_pkg::LOG_MAX_POINTS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [mwt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [mwt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic [mwt_pkg::INDEX_W-1:0]      i_index,
    input  wire logic [mwt_pkg::VAL_W-1:0]        i_value,
    input  wire mwt_pkg::t_cmd                    i_cmd,
    output mwt_pkg::t_stat                        o_stat,
    input  wire logic                             i_out_ready,
    output logic                                  o_out_valid,
    output logic      [mwt_pkg::VAL_W-1:0]        o_read_value,
    output logic                                  o_run_done
);

    import mwt_pkg::*;

    localparam int LW    = LOG_MAX_POINTS;
    localparam int SW    = $clog2(LOG_MAX_POINTS + 1);
    localparam int DEPTH = 2 ** LOG_MAX_POINTS;
    localparam logic [4:0] LogMax5 = 5'(LOG_MAX_POINTS);
    localparam logic [VAL_W:0] ModP31 = {1'b0, MOD_P};

    function automatic logic [VAL_W-1:0] add_mod(input logic [VAL_W-1:0] x,
                                                 input logic [VAL_W-1:0] y);
        logic [VAL_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        return (s >= ModP31) ? VAL_W'(s - ModP31) : s[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] sub_mod(input logic [VAL_W-1:0] x,
                                                 input logic [VAL_W-1:0] y);
        logic [VAL_W:0] t;
        t = {1'b0, x} + ModP31 - {1'b0, y};
        return (x >= y) ? (x - y) : t[VAL_W-1:0];
    endfunction

    // x * (p+1)/2 mod p: odd values borrow one p before halving
    function automatic logic [VAL_W-1:0] half_mod(input logic [VAL_W-1:0] x);
        logic [VAL_W:0] t;
        t = {1'b0, x} + ModP31;
        return x[0] ? t[VAL_W:1] : {1'b0, x[VAL_W-1:1]};
    endfunction

    // configuration
    logic [KIND_W-1:0] r_kind;
    logic              r_inverse;
    logic [SIZE_W-1:0] r_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind    <= KIND_OR;
            r_inverse <= 1'b0;
            r_size    <= SIZE_W'(10);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_KIND:    r_kind    <= i_cfg_data[KIND_W-1:0];
                CFG_INVERSE: r_inverse <= i_cfg_data[0];
                CFG_SIZE:    r_size    <= i_cfg_data[SIZE_W-1:0];
                default:     r_kind    <= r_kind;
            endcase
        end
    end

    // active size, saturated to the store depth
    logic [4:0]    size5;
    logic [4:0]    lg5;
    logic [SW-1:0] lg;

    assign size5 = {1'b0, r_size};
    assign lg5   = (size5 > LogMax5) ? LogMax5 : size5;
    assign lg    = SW'(lg5);

    // butterfly counters
    logic [SW-1:0] r_stage;
    logic [LW-1:0] r_bfly;
    logic [LW-1:0] bfly_last;
    logic [LW-1:0] low_mask;
    logic [LW-1:0] addr_lo;
    logic [LW-1:0] addr_hi;
    logic          last_bfly;
    logic          last_stage;

    assign bfly_last  = (LW'(1) << (lg - SW'(1))) - LW'(1);
    assign last_bfly  = (r_bfly == bfly_last);
    assign last_stage = (r_stage == (lg - SW'(1)));
    // lo has a zero inserted at bit r_stage of the butterfly number
    assign low_mask   = (LW'(1) << r_stage) - LW'(1);
    assign addr_lo    = ((r_bfly & ~low_mask) << 1) | (r_bfly & low_mask);
    assign addr_hi    = addr_lo | (LW'(1) << r_stage);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
            r_bfly  <= '0;
        end else if (i_cmd.clr_cnt) begin
            r_stage <= '0;
            r_bfly  <= '0;
        end else if (i_cmd.next_bfly) begin
            if (last_bfly) begin
                r_bfly  <= '0;
                r_stage <= r_stage + SW'(1);
            end else begin
                r_bfly  <= r_bfly + LW'(1);
            end
        end
    end

    // point store
    logic [LW-1:0]    in_addr;
    logic [VAL_W-1:0] in_val;
    logic             ram_wr_en;
    logic [LW-1:0]    ram_wr_addr;
    logic [VAL_W-1:0] ram_wr_data;
    logic [LW-1:0]    ram_rd_addr_a;
    logic [VAL_W-1:0] ram_rd_a;
    logic [VAL_W-1:0] ram_rd_b;

    assign in_addr = LW'(i_index);
    assign in_val  = (i_value >= MOD_P) ? (i_value - MOD_P) : i_value;

    // butterfly results
    logic [VAL_W-1:0] r_sum;
    logic [VAL_W-1:0] r_dif;   // x - y
    logic [VAL_W-1:0] r_difn;  // y - x
    logic [VAL_W-1:0] res_lo;
    logic [VAL_W-1:0] res_hi;

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_sum  <= add_mod(ram_rd_a, ram_rd_b);
            r_dif  <= sub_mod(ram_rd_a, ram_rd_b);
            r_difn <= sub_mod(ram_rd_b, ram_rd_a);
        end
    end

    always_comb begin
        if (r_kind == KIND_XOR) begin
            res_lo = r_inverse ? half_mod(r_sum) : r_sum;
            res_hi = r_inverse ? half_mod(r_dif) : r_dif;
        end else begin
            res_lo = r_inverse ? r_dif  : r_sum;
            res_hi = r_inverse ? r_difn : r_sum;
        end
    end

    always_comb begin
        ram_wr_en     = i_cmd.wr_in || i_cmd.wr_lo || i_cmd.wr_hi;
        ram_wr_addr   = addr_hi;
        ram_wr_data   = res_hi;
        if (i_cmd.wr_in) begin
            ram_wr_addr = in_addr;
            ram_wr_data = in_val;
        end else if (i_cmd.wr_lo) begin
            ram_wr_addr = addr_lo;
            ram_wr_data = res_lo;
        end
        ram_rd_addr_a = i_cmd.rd_in ? in_addr : addr_lo;
    end

    mwt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (ram_wr_en),
        .i_wr_addr   (ram_wr_addr),
        .i_wr_data   (ram_wr_data),
        .i_rd_addr_a (ram_rd_addr_a),
        .i_rd_addr_b (addr_hi),
        .o_rd_data_a (ram_rd_a),
        .o_rd_data_b (ram_rd_b)
    );

    // output register
    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_value;
    logic             r_out_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_read || i_cmd.out_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_read) begin
            r_out_value <= ram_rd_a;
            r_out_done  <= 1'b0;
        end else if (i_cmd.out_done) begin
            r_out_value <= '0;
            r_out_done  <= 1'b1;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_value;
    assign o_run_done   = r_out_done;

    assign o_stat.kind       = r_kind;
    assign o_stat.size_zero  = (lg == '0);
    assign o_stat.last_bfly  = last_bfly;
    assign o_stat.last_stage = last_stage;
    assign o_stat.out_hold   = r_out_valid && !i_out_ready;

endmodule

`default_nettype wire

### hdl/modular_walsh_transform.sv
`default_nettype none

// channel   direction  tdata (low bit up)                 tuser
// s_axis    in         index[9:0], value[39:10]           req_type[1:0]
// m_axis    out        read_value[29:0], zero pad [31:30] run_done[0]
// cfg       in         write enable, register index, data (no read-back)
//
// A write goes to the point store when accepted; a read passes through the store's
// registered read port and the output register. A run does log2(N) stages of N/2
// butterflies, N the active length, one at a time through the single write port of
// the point store; an unused kind or N = 1 goes straight to completion.
// Reset is synchronous and active low and clears control and configuration, not
// the point store. A stalled result holds the output and input waits until taken.

module modular_walsh_transform #(
    parameter int LOG_MAX_POINTS = mwt_pkg::LOG_MAX_POINTS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire logic [39:0]                     i_s_axis_tdata,  // index, value
    input  wire logic [mwt_pkg::REQ_W-1:0]       i_s_axis_tuser,  // req_type
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    output logic      [31:0]                     o_m_axis_tdata,  // read_value, pad
    output logic      [0:0]                      o_m_axis_tuser,  // run_done
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [mwt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [mwt_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import mwt_pkg::*;

    t_cmd             cmd;
    t_stat            stat;
    logic [VAL_W-1:0] read_value;
    logic             run_done;

    mwt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .i_req_type (i_s_axis_tuser),
        .o_ready    (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mwt_dpath #(
        .LOG_MAX_POINTS (LOG_MAX_POINTS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_index      (i_s_axis_tdata[INDEX_W-1:0]),
        .i_value      (i_s_axis_tdata[INDEX_W+VAL_W-1:INDEX_W]),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_read_value (read_value),
        .o_run_done   (run_done)
    );

    assign o_m_axis_tdata = {2'b00, read_value};
    assign o_m_axis_tuser = run_done;

endmodule

`default_nettype wire

### verif/mwt_checker.sv
`default_nettype none

module mwt_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    input  wire logic                           i_s_tready,
    input  wire logic [39:0]                    i_s_tdata,   // index[9:0], value[39:10]
    input  wire logic [mwt_pkg::REQ_W-1:0]      i_s_tuser,   // req_type
    input  wire logic                           i_m_tvalid,
    input  wire logic                           i_m_tready,
    input  wire logic [31:0]                    i_m_tdata,   // read_value[29:0], pad
    input  wire logic [0:0]                     i_m_tuser,   // run_done
    input  wire logic                           i_cfg_we,
    input  wire logic [mwt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mwt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                  o_errors,
    output int                                  o_pending
);

    import mwt_pkg::*;

    localparam int NPTS = 1 << LOG_MAX_POINTS_DEF;
    localparam longint unsigned PRIME = 64'(MOD_P);
    localparam longint unsigned HALF  = (PRIME + 1) >> 1;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic             run_done;
    } t_answer;

    logic [VAL_W-1:0]  vec [NPTS];
    logic [KIND_W-1:0] kind_r;
    logic              inv_r;
    logic [SIZE_W-1:0] size_r;
    t_answer           answers_due [$];
    t_answer           got;
    t_answer           want;
    logic [INDEX_W-1:0] idx;
    logic [VAL_W-1:0]  val;
    int                n_err = 0;

    function automatic logic [VAL_W-1:0] mod_sum(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        longint unsigned t;
        t = 64'(a) + 64'(b);
        return VAL_W'(t % PRIME);
    endfunction

    function automatic logic [VAL_W-1:0] mod_diff(input logic [VAL_W-1:0] a,
                                                  input logic [VAL_W-1:0] b);
        longint unsigned t;
        t = 64'(a) + PRIME - 64'(b);
        return VAL_W'(t % PRIME);
    endfunction

    function automatic logic [VAL_W-1:0] mod_half(input logic [VAL_W-1:0] a);
        longint unsigned t;
        t = 64'(a) * HALF;
        return VAL_W'(t % PRIME);
    endfunction

    // in-place butterfly passes over the active span
    function automatic void transform_points();
        int unsigned lg, span, h, base, k;
        logic [VAL_W-1:0] x, y, s, d;
        lg = (size_r > LOG_MAX_POINTS_DEF) ? LOG_MAX_POINTS_DEF : size_r;
        span = 1 << lg;
        if (kind_r != KIND_OR && kind_r != KIND_AND && kind_r != KIND_XOR)
            return;
        for (h = 1; h < span; h = h << 1) begin
            for (base = 0; base < span; base = base + 2 * h) begin
                for (k = 0; k < h; k++) begin
                    x = vec[base + k];
                    y = vec[base + k + h];
                    case (kind_r)
                        KIND_OR: begin
                            vec[base + k + h] = inv_r ? mod_diff(y, x) : mod_sum(x, y);
                        end
                        KIND_AND: begin
                            vec[base + k] = inv_r ? mod_diff(x, y) : mod_sum(x, y);
                        end
                        default: begin
                            s = mod_sum(x, y);
                            d = mod_diff(x, y);
                            if (inv_r) begin
                                s = mod_half(s);
                                d = mod_half(d);
                            end
                            vec[base + k]     = s;
                            vec[base + k + h] = d;
                        end
                    endcase
                end
            end
        end
    endfunction

    initial begin
        for (int i = 0; i < NPTS; i++)
            vec[i] = '0;
        kind_r = KIND_OR;
        inv_r  = 1'b0;
        size_r = SIZE_W'(10);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            kind_r = KIND_OR;
            inv_r  = 1'b0;
            size_r = SIZE_W'(10);
            answers_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.read_value = i_m_tdata[VAL_W-1:0];
                got.run_done   = i_m_tuser[0];
                if (answers_due.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("unexpected result: read_value %0d run_done %0b",
                                 got.read_value, got.run_done);
                end else begin
                    want = answers_due.pop_front();
                    if (want.read_value !== got.read_value ||
                            want.run_done !== got.run_done) begin
                        n_err++;
                        if (n_err <= 10)
                            $display({"mismatch: expected read_value %0d run_done %0b,",
                                      " got %0d %0b"},
                                     want.read_value, want.run_done,
                                     got.read_value, got.run_done);
                    end
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                idx = i_s_tdata[INDEX_W-1:0];
                val = i_s_tdata[INDEX_W +: VAL_W];
                case (i_s_tuser)
                    REQ_WRITE: begin
                        vec[idx] = (val >= MOD_P) ? val - MOD_P : val;
                    end
                    REQ_RUN: begin
                        transform_points();
                        answers_due.push_back('{read_value: '0, run_done: 1'b1});
                    end
                    REQ_READ: begin
                        answers_due.push_back('{read_value: vec[idx], run_done: 1'b0});
                    end
                    default: ; // unused request type: ignored
                endcase
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KIND:    kind_r = i_cfg_data[KIND_W-1:0];
                    CFG_INVERSE: inv_r  = i_cfg_data[0];
                    CFG_SIZE:    size_r = i_cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending <= answers_due.size();
        o_errors  <= n_err;
    end

endmodule

`default_nettype wire

### verif/modular_walsh_transform_tb.sv
`default_nettype none

module modular_walsh_transform_tb;
    import mwt_pkg::*;

    localparam logic [REQ_W-1:0]     REQ_NONE   = 2'd3;
    localparam logic [KIND_W-1:0]    KIND_NONE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int NPTS        = 1 << LOG_MAX_POINTS_DEF;
    localparam int TARGET      = 1100;
    localparam int STALL_LIMIT = 100000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [39:0]           s_tdata;   // index[9:0], value[39:10]
    logic [REQ_W-1:0]      s_tuser;   // req_type
    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;   // read_value[29:0], pad
    logic [0:0]            m_tuser;   // run_done
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_dat;

    int ck_errors;
    int ck_pending;

    bit src_gaps  = 1'b1;
    bit sink_gaps = 1'b1;
    bit hold_req  = 1'b0;

    bit written [NPTS];
    int written_list [$];
    int cur_span = NPTS;
    int sent = 0;

    modular_walsh_transform dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_wr_en     (cfg_we),
        .i_cfg_index     (cfg_idx),
        .i_cfg_data      (cfg_dat)
    );

    mwt_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_idx),
        .i_cfg_data  (cfg_dat),
        .o_errors    (ck_errors),
        .o_pending   (ck_pending)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [VAL_W-1:0] rand_value();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return MOD_P - 1;
        if (r <= 3)  // unreduced, up to all ones
            return VAL_W'($urandom_range(1073741823, 1000000007));
        return VAL_W'($urandom_range(1000000006, 0));
    endfunction

    task automatic send_item(input logic [REQ_W-1:0] req, input int idx,
                             input logic [VAL_W-1:0] val);
        // no idling in the last part of the run
        if (sent >= TARGET - 150) begin
            src_gaps  = 1'b0;
            sink_gaps = 1'b0;
        end
        if (src_gaps && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {val, INDEX_W'(idx)};
        s_tuser  <= req;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent++;
        if (req == REQ_WRITE && !written[idx]) begin
            written[idx] = 1'b1;
            written_list.push_back(idx);
        end
    endtask

    task automatic read_any();
        send_item(REQ_READ, written_list[$urandom_range(0, written_list.size() - 1)],
                  VAL_W'($urandom));
    endtask

    task automatic run_now();
        send_item(REQ_RUN, $urandom_range(0, NPTS - 1), VAL_W'($urandom));
    endtask

    // a run may only cover points that hold a value
    task automatic cover_span();
        for (int i = 0; i < cur_span; i++)
            if (!written[i])
                send_item(REQ_WRITE, i, rand_value());
    endtask

    // registers change only once the unit has gone quiet
    task automatic set_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (ck_pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);
        cfg_we  <= 1'b1;
        cfg_idx <= idx;
        cfg_dat <= data;
        @(posedge clk);
        cfg_we  <= 1'b0;
        if (idx == CFG_SIZE)
            cur_span = 1 << ((data > LOG_MAX_POINTS_DEF) ? LOG_MAX_POINTS_DEF : data);
    endtask

    // result side: random back-pressure plus one long hold on request
    initial begin : sink_ctl
        int gap_left;
        int hold_left;
        gap_left  = 0;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 250;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                m_tready <= 1'b0;
            end else if (sink_gaps && $urandom_range(0, 9) == 0) begin
                gap_left = $urandom_range(1, 18) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if (rst_n) begin
                if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                    quiet = 0;
                else
                    quiet++;
                if (quiet >= STALL_LIMIT) begin
                    $display("modular_walsh_transform verification failed");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        int phase;
        int n;
        int r;
        logic [KIND_W-1:0] kind;
        logic [CFG_DATA_W-1:0] sz;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = REQ_WRITE;
        cfg_we   = 1'b0;
        cfg_idx  = CFG_KIND;
        cfg_dat  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, unreduced values, every kind and direction
        set_cfg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 15)));
        set_cfg(CFG_SIZE, 4'd2);
        send_item(REQ_WRITE, 0, '0);
        send_item(REQ_WRITE, 1, MOD_P - 1);
        send_item(REQ_WRITE, 2, '1);
        send_item(REQ_WRITE, 3, MOD_P);
        send_item(REQ_WRITE, NPTS - 1, VAL_W'(123456789));
        for (int i = 0; i < 4; i++)
            send_item(REQ_READ, i, VAL_W'($urandom));
        send_item(REQ_READ, NPTS - 1, '1);
        send_item(REQ_NONE, NPTS - 1, '1);
        run_now();
        send_item(REQ_READ, 3, '0);
        set_cfg(CFG_KIND, CFG_DATA_W'(KIND_AND));
        set_cfg(CFG_INVERSE, 4'd1);
        run_now();
        send_item(REQ_READ, 0, '0);
        set_cfg(CFG_KIND, CFG_DATA_W'(KIND_XOR));
        set_cfg(CFG_INVERSE, 4'd0);
        run_now();
        set_cfg(CFG_INVERSE, 4'd1);
        run_now();
        for (int i = 0; i < 4; i++)
            send_item(REQ_READ, i, '0);
        set_cfg(CFG_KIND, CFG_DATA_W'(KIND_NONE));
        run_now();
        set_cfg(CFG_SIZE, 4'd0);
        run_now();
        send_item(REQ_READ, 0, '0);

        // filling the whole vector takes most of the items
        phase = 0;
        while (sent < TARGET || phase < 4) begin
            phase++;
            r = $urandom_range(0, 9);
            kind = (r < 3) ? KIND_OR : (r < 6) ? KIND_AND : (r < 9) ? KIND_XOR : KIND_NONE;
            set_cfg(CFG_KIND, {2'($urandom_range(0, 3)), kind});
            set_cfg(CFG_INVERSE, CFG_DATA_W'($urandom_range(0, 15)));
            // whole vector once with an oversized setting, once at full size
            if (phase == 3)
                sz = 4'd15;
            else if (phase == 4)
                sz = 4'd10;
            else if ($urandom_range(0, 9) == 0)
                sz = CFG_DATA_W'($urandom_range(6, 8));
            else
                sz = CFG_DATA_W'($urandom_range(0, 5));
            set_cfg(CFG_SIZE, sz);
            cover_span();

            if (phase == 2) begin
                // long result stall: the unit fills and refuses input
                hold_req = 1'b1;
                repeat (16) read_any();
            end

            n = $urandom_range(12, 30);
            repeat (n) begin
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    send_item(REQ_WRITE, $urandom_range(0, cur_span - 1), rand_value());
                end else if (r < 45) begin
                    send_item(REQ_WRITE, $urandom_range(0, NPTS - 1), rand_value());
                end else if (r < 75) begin
                    read_any();
                end else if (r < 88) begin
                    run_now();
                end else if (r < 95) begin
                    send_item(REQ_NONE, $urandom_range(0, NPTS - 1), VAL_W'($urandom));
                end else begin
                    run_now();
                    read_any();
                end
            end
            run_now();
            read_any();
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (ck_pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (ck_errors == 0)
            $display("modular_walsh_transform verification clean");
        else
            $display("modular_walsh_transform verification failed");
        $finish;
    end

endmodule

`default_nettype wire
